>>> hw/rtl/clump_to_superclump_merge_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the clump to superclump merge block
// ----------------------------------------------------------------------------
`ifndef CLUMP_TO_SUPERCLUMP_MERGE_ASSERT_SVH
`define CLUMP_TO_SUPERCLUMP_MERGE_ASSERT_SVH

// checked only out of reset
`define CSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("csm assertion failed");

// checked at every edge, reset included
`define CSM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("csm assertion failed");

`endif

>>> hw/rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// shared types and constants of the clump to superclump merge block
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int RANK_WIDTH  = 16;
    localparam int DATA_WIDTH  = ((RANK_WIDTH + 7) / 8) * 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [RANK_WIDTH-1:0] rank_t;
    typedef logic [RANK_WIDTH:0]   rank_sum_t;

    typedef struct packed {
        rank_t rank;
        logic  run_last;
        logic  partition_done;
    } cut_t;

    typedef struct packed {
        logic [1:0] num;
        cut_t       cut0;
        cut_t       cut1;
    } push_t;

    function automatic cut_t make_cut(rank_t rank, logic run_last, logic done);
        cut_t c;
        c.rank           = rank;
        c.run_last       = run_last;
        c.partition_done = done;
        return c;
    endfunction

endpackage

>>> hw/rtl/csm_front.sv
// ----------------------------------------------------------------------------
// csm_front
// accepts clump ends, keeps the cut state and decides the cuts of each item
// ----------------------------------------------------------------------------
module csm_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  csm_pkg::rank_t                cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  csm_pkg::rank_t                in_rank,
    input  logic                          in_final,
    input  logic                          room,
    output csm_pkg::push_t                push
);

    csm_pkg::rank_t    target_reg,    target_next;
    csm_pkg::rank_t    last_cut_reg,  last_cut_next;
    logic              pend_vld_reg,  pend_vld_next;
    csm_pkg::rank_t    pend_cut_reg,  pend_cut_next;
    csm_pkg::rank_t    pend_span_reg, pend_span_next;

    logic              accept;
    csm_pkg::rank_t    span;
    csm_pkg::rank_t    step;
    csm_pkg::rank_sum_t sum;
    csm_pkg::rank_sum_t tgt_wide;
    logic              new_closer;

    assign in_ready = room;
    assign accept   = in_valid && room;

    assign span     = in_rank - last_cut_reg;
    assign step     = in_rank - pend_cut_reg;
    assign sum      = {1'b0, step} + {1'b0, pend_span_reg};
    assign tgt_wide = {1'b0, target_reg};
    // a held span above the target (target lowered while held) always takes the new end
    assign new_closer = (pend_span_reg > target_reg) ||
                        ({1'b0, target_reg - pend_span_reg} > (sum - tgt_wide));

    always_comb
    begin
        target_next    = cfg_we ? cfg_wdata : target_reg;
        last_cut_next  = last_cut_reg;
        pend_vld_next  = pend_vld_reg;
        pend_cut_next  = pend_cut_reg;
        pend_span_next = pend_span_reg;
        push.num       = 2'd0;
        push.cut0      = csm_pkg::make_cut(in_rank, 1'b1, 1'b0);
        push.cut1      = csm_pkg::make_cut(in_rank, 1'b1, 1'b0);
        if (accept)
        begin
            if (in_final)
            begin
                if (in_rank != last_cut_reg)
                begin
                    push.num  = 2'd1;
                    push.cut0 = csm_pkg::make_cut(in_rank, 1'b1, 1'b1);
                end
                last_cut_next  = '0;
                pend_vld_next  = 1'b0;
                pend_cut_next  = '0;
                pend_span_next = '0;
            end
            else if (!pend_vld_reg)
            begin
                if (span < target_reg)
                begin
                    pend_span_next = span;
                    pend_cut_next  = in_rank;
                    pend_vld_next  = 1'b1;
                end
                else
                begin
                    last_cut_next = in_rank;
                    push.num      = 2'd1;
                end
            end
            else if (sum < tgt_wide)
            begin
                pend_span_next = sum[csm_pkg::RANK_WIDTH-1:0];
                pend_cut_next  = in_rank;
            end
            else if (new_closer)
            begin
                last_cut_next  = in_rank;
                pend_vld_next  = 1'b0;
                pend_cut_next  = '0;
                pend_span_next = '0;
                push.num       = 2'd1;
            end
            else if (step >= target_reg)
            begin
                // pending end first, then the new end
                push.num       = 2'd2;
                push.cut0      = csm_pkg::make_cut(pend_cut_reg, 1'b0, 1'b0);
                last_cut_next  = in_rank;
                pend_vld_next  = 1'b0;
                pend_cut_next  = '0;
                pend_span_next = '0;
            end
            else
            begin
                push.num       = 2'd1;
                push.cut0      = csm_pkg::make_cut(pend_cut_reg, 1'b1, 1'b0);
                last_cut_next  = pend_cut_reg;
                pend_span_next = step;
                pend_cut_next  = in_rank;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= csm_pkg::rank_t'(1);
            last_cut_reg  <= '0;
            pend_vld_reg  <= 1'b0;
            pend_cut_reg  <= '0;
            pend_span_reg <= '0;
        end
        else
        begin
            target_reg    <= target_next;
            last_cut_reg  <= last_cut_next;
            pend_vld_reg  <= pend_vld_next;
            pend_cut_reg  <= pend_cut_next;
            pend_span_reg <= pend_span_next;
        end
    end

endmodule

>>> hw/rtl/csm_queue.sv
// ----------------------------------------------------------------------------
// csm_queue
// small cut queue, takes up to two cuts a cycle and gives one
// ----------------------------------------------------------------------------
module csm_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  csm_pkg::push_t  push,
    output logic            room,
    output logic            head_valid,
    output csm_pkg::cut_t   head,
    input  logic            pop
);

    csm_pkg::cut_t                     mem [csm_pkg::QUEUE_DEPTH];
    logic [csm_pkg::QPTR_WIDTH-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [csm_pkg::QPTR_WIDTH-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [csm_pkg::QCNT_WIDTH-1:0]    count_reg,  count_next;
    logic [csm_pkg::QPTR_WIDTH-1:0]    wr_ptr_plus1;

    // room for two beats, so a full item always fits
    assign room       = count_reg <= csm_pkg::QCNT_WIDTH'(csm_pkg::QUEUE_DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + csm_pkg::QPTR_WIDTH'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + csm_pkg::QPTR_WIDTH'(push.num);
        rd_ptr_next = rd_ptr_reg + csm_pkg::QPTR_WIDTH'(pop);
        count_next  = count_reg + csm_pkg::QCNT_WIDTH'(push.num)
                      - csm_pkg::QCNT_WIDTH'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.cut0;
        end
        if (push.num == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.cut1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/csm_back.sv
// ----------------------------------------------------------------------------
// csm_back
// output register that drives cut beats to the receiver
// ----------------------------------------------------------------------------
module csm_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  csm_pkg::cut_t   head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output csm_pkg::cut_t   out_cut
);

    logic          valid_reg, valid_next;
    csm_pkg::cut_t cut_reg,   cut_next;

    assign pop       = head_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_cut   = cut_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cut_next   = cut_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            cut_next   = head;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cut_reg <= cut_next;
    end

endmodule

>>> hw/rtl/clump_to_superclump_merge.sv
// ----------------------------------------------------------------------------
// clump_to_superclump_merge
// merges consecutive clumps into superclumps close to a target size
// ----------------------------------------------------------------------------
// input stream: clump end ranks in increasing order on s_axis_tdata, tlast
// marks the final beat, whose data is the total sample count.
// output stream: one beat per committed cut; tlast is high on the last cut of
// an input beat, tuser is high on the cut that closes the partition.
// config: cfg_we writes target_size from cfg_wdata; the user must do so only
// while idle; the block does not enforce it. Each cut is decided in the
// accepting cycle, queued, then put on m_axis_tvalid by the output register.
// throughput: one input beat per cycle while each beat makes at most one
// cut and the receiver keeps up; a second cut of a beat is absorbed by the
// four-entry queue. s_axis_tready drops if fewer than two entries are free.
// reset: state, queue and output register clear, target_size goes to 1.
// receiver stall: the output register holds its beat, the queue fills and
// then back-pressures the input.
// ----------------------------------------------------------------------------
module clump_to_superclump_merge
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [csm_pkg::RANK_WIDTH-1:0]    cfg_wdata,    // target_size
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [csm_pkg::DATA_WIDTH-1:0]    s_axis_tdata, // clump_end
    input  logic                              s_axis_tlast, // final_item
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [csm_pkg::DATA_WIDTH-1:0]    m_axis_tdata, // cut_rank
    output logic                              m_axis_tlast, // run_last
    output logic                              m_axis_tuser  // partition_done
);

    csm_pkg::push_t push;
    logic           room;
    logic           head_valid;
    csm_pkg::cut_t  head;
    logic           pop;
    csm_pkg::cut_t  out_cut;

    csm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_rank   (s_axis_tdata[csm_pkg::RANK_WIDTH-1:0]),
        .in_final  (s_axis_tlast),
        .room      (room),
        .push      (push)
    );

    csm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    csm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_cut    (out_cut)
    );

    assign m_axis_tdata = csm_pkg::DATA_WIDTH'(out_cut.rank);
    assign m_axis_tlast = out_cut.run_last;
    assign m_axis_tuser = out_cut.partition_done;

endmodule

>>> hw/rtl/csm_checker.sv
// ----------------------------------------------------------------------------
// csm_checker
// port-level checks of the clump to superclump merge block
// ----------------------------------------------------------------------------
`include "clump_to_superclump_merge_assert.svh"

module csm_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [csm_pkg::DATA_WIDTH-1:0]    m_axis_tdata,
    input  logic                              m_axis_tlast,
    input  logic                              m_axis_tuser
);

    logic                             out_stall;
    logic [csm_pkg::DATA_WIDTH+1:0]   out_beat;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_beat  = {m_axis_tdata, m_axis_tlast, m_axis_tuser};

    // the closing cut is always the last cut of its beat
    `CSM_ASSERT(a_done_is_last, clk, rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)

    // nothing leaves after an edge seen in reset
    `CSM_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |=> !m_axis_tvalid)

    // an empty output register means the queue has room for a beat
    `CSM_ASSERT(a_ready_when_idle, clk, rst_n, !m_axis_tvalid |-> s_axis_tready)

    // stalled beat holds
    `CSM_ASSERT(a_out_hold, clk, rst_n, out_stall |=> m_axis_tvalid && $stable(out_beat))

endmodule

bind clump_to_superclump_merge csm_checker u_csm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

>>> test/clump_to_superclump_merge_test.sv
// ----------------------------------------------------------------------------
// clump_to_superclump_merge_test
// Drives mostly sorted clump end ranks and final totals into the superclump
// merge block under several target sizes, with random gaps on the input and
// random stalls on the output. A behavioral cut predictor builds the
// expected cut beats, and every output beat is checked against them in order.
// ----------------------------------------------------------------------------
module clump_to_superclump_merge_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE      = 12;

    // predicts the committed cuts from the accepted clump beats
    class cut_tracker;
        csm_pkg::rank_t target;
        csm_pkg::rank_t last_cut;
        bit             held;
        csm_pkg::rank_t held_cut;
        csm_pkg::rank_t held_span;
        csm_pkg::cut_t  cuts_due[$];
        int unsigned    faults;
        int unsigned    cuts_seen;
        int unsigned    clumps_seen;

        function new();
            target      = 1;
            faults      = 0;
            cuts_seen   = 0;
            clumps_seen = 0;
            clear_run();
        endfunction

        function void clear_run();
            last_cut  = '0;
            held      = 1'b0;
            held_cut  = '0;
            held_span = '0;
        endfunction

        function void set_target(csm_pkg::rank_t v);
            target = v;
        endfunction

        function void add_cut(csm_pkg::rank_t r, logic last, logic done);
            csm_pkg::cut_t c;
            c.rank           = r;
            c.run_last       = last;
            c.partition_done = done;
            cuts_due.push_back(c);
        endfunction

        function void take_clump(csm_pkg::rank_t r, logic fin);
            csm_pkg::rank_t span;
            csm_pkg::rank_t step;
            int unsigned    sum;
            int unsigned    tgt;
            clumps_seen++;
            tgt = target;
            if (fin)
            begin
                if (r != last_cut)
                    add_cut(r, 1'b1, 1'b1);
                clear_run();
                return;
            end
            if (!held)
            begin
                span = r - last_cut;
                if (span < tgt)
                begin
                    held_span = span;
                    held_cut  = r;
                    held      = 1'b1;
                end
                else
                begin
                    last_cut = r;
                    add_cut(r, 1'b1, 1'b0);
                end
                return;
            end
            step = r - held_cut;
            sum  = step + held_span;
            if (sum < tgt)
            begin
                held_span = csm_pkg::rank_t'(sum);
                held_cut  = r;
            end
            else if ((tgt - held_span) > (sum - tgt))
            begin
                // new end lands closer to the target, held end is skipped
                add_cut(r, 1'b1, 1'b0);
                clear_run();
                last_cut = r;
            end
            else if (step >= tgt)
            begin
                add_cut(held_cut, 1'b0, 1'b0);
                add_cut(r, 1'b1, 1'b0);
                clear_run();
                last_cut = r;
            end
            else
            begin
                // commit the held end, new end starts the next span
                add_cut(held_cut, 1'b1, 1'b0);
                last_cut  = held_cut;
                held_span = step;
                held_cut  = r;
            end
        endfunction

        function void match_cut(csm_pkg::rank_t r, logic last, logic done);
            csm_pkg::cut_t want;
            if (cuts_due.size() == 0)
            begin
                faults++;
                $display("%0t: unexpected cut beat, expected none, got rank %0d last %0b done %0b",
                         $time, r, last, done);
                return;
            end
            want = cuts_due.pop_front();
            cuts_seen++;
            if (want.rank != r)
            begin
                faults++;
                $display("%0t: cut_rank expected %0d, got %0d", $time, want.rank, r);
            end
            if (want.run_last != last)
            begin
                faults++;
                $display("%0t: run_last expected %0b, got %0b (rank %0d)",
                         $time, want.run_last, last, want.rank);
            end
            if (want.partition_done != done)
            begin
                faults++;
                $display("%0t: partition_done expected %0b, got %0b (rank %0d)",
                         $time, want.partition_done, done, want.rank);
            end
        endfunction

        function int unsigned waiting();
            return cuts_due.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n         = 1'b0;
    logic                           cfg_we        = 1'b0;
    csm_pkg::rank_t                 cfg_wdata     = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [csm_pkg::DATA_WIDTH-1:0] s_axis_tdata  = '0;
    logic                           s_axis_tlast  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [csm_pkg::DATA_WIDTH-1:0] m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           m_axis_tuser;

    cut_tracker  tracker;
    bit          calm         = 1'b1;
    int unsigned cycle_count  = 0;
    int unsigned target_count = 0;

    clump_to_superclump_merge u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d cuts still due", cycle_count, tracker.waiting());
        $display("== FAIL ==");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // output side: check each accepted beat, then pick tready for the next edge
    initial
    begin
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                tracker.match_cut(csm_pkg::rank_t'(m_axis_tdata), m_axis_tlast, m_axis_tuser);
            if (hold == 0)
                hold = pick_gap();
            if (hold != 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_clump(input csm_pkg::rank_t r, input logic fin);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= csm_pkg::DATA_WIDTH'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= csm_pkg::DATA_WIDTH'(r);
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_clump(r, fin);
    endtask

    task automatic drain_cuts();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.waiting() != 0)
            @(posedge clk);
    endtask

    // waits until the block has gone quiet, then writes the target
    task automatic write_target(input csm_pkg::rank_t v);
        drain_cuts();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= csm_pkg::rank_t'($urandom);
        tracker.set_target(v);
        target_count++;
    endtask

    // mostly increasing clump runs closed by a total, some stray beats
    task automatic run_random(input int unsigned count, input int unsigned tgt);
        int unsigned sent;
        int unsigned pos;
        int unsigned inc;
        int unsigned half;
        int unsigned n;
        int unsigned k;
        int unsigned sel;
        sent = 0;
        half = (tgt / 2 == 0) ? 1 : tgt / 2;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                send_clump(csm_pkg::rank_t'($urandom_range(1, 65535)),
                           $urandom_range(0, 3) == 0);
                sent++;
            end
            else
            begin
                n   = $urandom_range(1, 12);
                pos = 0;
                for (k = 0; k < n; k++)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        inc = 0;
                    else if (sel < 6)
                        inc = $urandom_range(1, half);
                    else if (sel < 9)
                        inc = $urandom_range(half, tgt * 2);
                    else
                        inc = $urandom_range(tgt, tgt * 4);
                    if (pos + inc == 0)
                        inc = 1;
                    if (pos + inc > 65535)
                        break;
                    pos = pos + inc;
                    send_clump(csm_pkg::rank_t'(pos), 1'b0);
                    sent++;
                end
                inc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, tgt);
                if (pos + inc > 65535)
                    inc = 65535 - pos;
                if (pos + inc == 0)
                    inc = 1;
                send_clump(csm_pkg::rank_t'(pos + inc), 1'b1);
                sent++;
            end
        end
    endtask

    initial
    begin
        csm_pkg::rank_t tgt;
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset target of one: repeated rank, double cut, wrap, total equal to last cut
        send_clump(16'd1, 1'b0);
        send_clump(16'd1, 1'b0);
        send_clump(16'd3, 1'b0);
        send_clump(16'd65535, 1'b0);
        send_clump(16'd65535, 1'b1);
        send_clump(16'd65535, 1'b0);
        send_clump(16'd2, 1'b0);
        send_clump(16'd7, 1'b1);

        // target of ten: each way a held span can resolve
        write_target(16'd10);
        calm = 1'b0;
        send_clump(16'd4, 1'b0);
        send_clump(16'd8, 1'b0);
        send_clump(16'd11, 1'b0);
        send_clump(16'd15, 1'b0);
        send_clump(16'd22, 1'b0);
        send_clump(16'd30, 1'b0);
        send_clump(16'd35, 1'b0);
        send_clump(16'd50, 1'b0);
        send_clump(16'd52, 1'b0);
        send_clump(16'd60, 1'b1);
        send_clump(16'd100, 1'b0);
        send_clump(16'd40, 1'b0);
        send_clump(16'd40, 1'b1);

        write_target(16'd65535);
        run_random(60, 65535);

        tgt = csm_pkg::rank_t'($urandom_range(2, 16));
        write_target(tgt);
        run_random(60, tgt);
        // hold off the input until every cut has come out
        drain_cuts();
        run_random(60, tgt);

        tgt = csm_pkg::rank_t'($urandom_range(17, 300));
        write_target(tgt);
        calm = 1'b1;
        run_random(110, tgt);

        tgt = csm_pkg::rank_t'($urandom_range(1000, 20000));
        write_target(tgt);
        calm = 1'b0;
        run_random(60, tgt);

        write_target(16'd1);
        run_random(100, 1);

        drain_cuts();
        repeat (SETTLE) @(posedge clk);

        $display("%0d clump beats sent under %0d written targets, %0d cut beats checked",
                 tracker.clumps_seen, target_count, tracker.cuts_seen);
        $display("%0d mismatches, %0d cuts left unmatched", tracker.faults, tracker.waiting());
        if (tracker.faults == 0 && tracker.waiting() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/csm_pkg.sv
hw/rtl/csm_front.sv
hw/rtl/csm_queue.sv
hw/rtl/csm_back.sv
hw/rtl/clump_to_superclump_merge.sv
hw/rtl/csm_checker.sv
test/clump_to_superclump_merge_test.sv
